>>> hw/rtl/strain_median_peak_stats_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strain median / peak statistics block
// Shared concurrent property wrappers, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef STRAIN_MEDIAN_PEAK_STATS_TOP_MACROS_SVH
`define STRAIN_MEDIAN_PEAK_STATS_TOP_MACROS_SVH

// same-cycle implication
`define SMPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/smps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_pkg
// Shared constants, register map and controller/datapath interface types.
// ----------------------------------------------------------------------------
package smps_pkg;

   localparam int MEDIAN_SAMPLES_DEF = 5;
   localparam int REPEATS_DEF        = 5;
   localparam int FRAC_BITS_DEF      = 8;

   localparam int SAMPLE_W   = 24;
   localparam int OUT_W      = 25;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic CSR_GAUGE_RECIP = 1'b0;
   localparam logic CSR_ZERO_OFFSET = 1'b1;

   localparam logic [SAMPLE_W-1:0] GAUGE_RECIP_RST = 24'd15753;

   localparam logic signed [OUT_W-1:0] MEAN_HI  = 25'sd16777215;
   localparam logic signed [OUT_W-1:0] MEAN_LO  = -25'sd16777216;
   localparam logic        [OUT_W-1:0] RANGE_HI = 25'h1FF_FFFF;

   typedef struct packed {
      logic mul_load;   // latch product of incoming sample
      logic win_write;  // store scaled sample at window index
      logic med_test;   // test candidate at window index
      logic upd;        // fold median into running max/min
      logic fin_sum;    // form max+min and max-min
      logic out_load;   // load result register
      logic clear;      // reset running max/min
   } dp_cmd_type;

   typedef struct packed {
      logic med_found;
      logic out_free;
   } dp_stat_type;

endpackage

>>> hw/rtl/strain_median_peak_stats_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strain_median_peak_stats_top
// Scales bridge ADC samples to fixed-point strain, takes the median of each
// group, tracks max/min over the groups and emits midpoint and range.
// ----------------------------------------------------------------------------
// Channel   Ports      Payload
// req       req_t*     tdata[23:0] raw_sample
// rsp       rsp_t*     tdata[24:0] mean_strain, [49:25] range_strain
// csr       csr_p*     0x0 gauge_recip, 0x4 zero_offset
//
// A sample passes a multiply step and a scale/store step before the next is taken.
// A sample closing a group adds the median sweep, which tests candidates in turn
// until the median is found, then an update step; the run's last sample adds a sum step
// and an output load step. Reset is synchronous; no clearing pass is needed.
// A stalled rsp channel holds the block only when a new result is ready while
// the result register is still full.
// ----------------------------------------------------------------------------
module strain_median_peak_stats_top #(
   parameter int MEDIAN_SAMPLES = smps_pkg::MEDIAN_SAMPLES_DEF,
   parameter int REPEATS        = smps_pkg::REPEATS_DEF,
   parameter int FRAC_BITS      = smps_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [smps_pkg::SAMPLE_W-1:0]       req_tdata,   // [23:0] raw_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [smps_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [24:0] mean, [49:25] range
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [smps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [smps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [smps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W = (MEDIAN_SAMPLES > 1) ? $clog2(MEDIAN_SAMPLES) : 1;

   logic [smps_pkg::SAMPLE_W-1:0]        gauge_recip;
   logic signed [smps_pkg::SAMPLE_W-1:0] zero_offset;
   smps_pkg::dp_cmd_type                 cmd;
   smps_pkg::dp_stat_type                stat;
   logic [IDX_W-1:0]                     idx;

   assign csr_pready = 1'b1;

   smps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_index   (csr_paddr[2]),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .gauge_recip (gauge_recip),
      .zero_offset (zero_offset)
   );

   smps_ctrl #(
      .MEDIAN_SAMPLES (MEDIAN_SAMPLES),
      .REPEATS        (REPEATS),
      .IDX_W          (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .idx        (idx),
      .stat       (stat)
   );

   smps_dp #(
      .MEDIAN_SAMPLES (MEDIAN_SAMPLES),
      .FRAC_BITS      (FRAC_BITS),
      .IDX_W          (IDX_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .gauge_recip (gauge_recip),
      .zero_offset (zero_offset),
      .cmd         (cmd),
      .idx         (idx),
      .stat        (stat),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> hw/rtl/smps_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_csr
// APB register file: gauge reciprocal and zero offset.
// ----------------------------------------------------------------------------
module smps_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic                                   csr_index,
   input  logic [smps_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [smps_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic [smps_pkg::SAMPLE_W-1:0]          gauge_recip,
   output logic signed [smps_pkg::SAMPLE_W-1:0]   zero_offset
);

   logic [smps_pkg::SAMPLE_W-1:0]        recip_ff,  recip_in;
   logic signed [smps_pkg::SAMPLE_W-1:0] offset_ff, offset_in;
   logic                                 wr_en;

   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      recip_in  = recip_ff;
      offset_in = offset_ff;
      if (wr_en) begin
         unique case (csr_index)
            smps_pkg::CSR_GAUGE_RECIP: recip_in  = csr_pwdata[smps_pkg::SAMPLE_W-1:0];
            smps_pkg::CSR_ZERO_OFFSET: offset_in = $signed(csr_pwdata[smps_pkg::SAMPLE_W-1:0]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff  <= smps_pkg::GAUGE_RECIP_RST;
         offset_ff <= '0;
      end else begin
         recip_ff  <= recip_in;
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         smps_pkg::CSR_GAUGE_RECIP: csr_prdata = smps_pkg::CSR_DATA_W'(recip_ff);
         smps_pkg::CSR_ZERO_OFFSET: csr_prdata = smps_pkg::CSR_DATA_W'(offset_ff);
      endcase
   end

   assign gauge_recip = recip_ff;
   assign zero_offset = offset_ff;

endmodule

>>> hw/rtl/smps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_dp
// Datapath: scaling multiplier, sample window, median test, peak tracking,
// final midpoint/range with saturation and the result register.
// ----------------------------------------------------------------------------
module smps_dp #(
   parameter int MEDIAN_SAMPLES = smps_pkg::MEDIAN_SAMPLES_DEF,
   parameter int FRAC_BITS      = smps_pkg::FRAC_BITS_DEF,
   parameter int IDX_W          = (MEDIAN_SAMPLES > 1) ? $clog2(MEDIAN_SAMPLES) : 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [smps_pkg::SAMPLE_W-1:0]          req_tdata,
   input  logic [smps_pkg::SAMPLE_W-1:0]          gauge_recip,
   input  logic signed [smps_pkg::SAMPLE_W-1:0]   zero_offset,
   input  smps_pkg::dp_cmd_type                   cmd,
   input  logic [IDX_W-1:0]                       idx,
   output smps_pkg::dp_stat_type                  stat,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [smps_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int SHIFT  = smps_pkg::SAMPLE_W - FRAC_BITS;
   localparam int PROD_W = 2 * smps_pkg::SAMPLE_W + 1;
   localparam int WIN_W  = FRAC_BITS + 26;
   localparam int SUM_W  = WIN_W + 1;
   localparam int CNT_W  = $clog2(MEDIAN_SAMPLES + 1);
   localparam int MID    = MEDIAN_SAMPLES / 2;
   localparam int PAD_W  = smps_pkg::RSP_DATA_W - 2 * smps_pkg::OUT_W;

   localparam logic signed [WIN_W-1:0] RUN_MIN   = {1'b1, {(WIN_W-1){1'b0}}};
   localparam logic signed [WIN_W-1:0] RUN_MAX   = {1'b0, {(WIN_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] MEAN_BIAS = {{(SUM_W-FRAC_BITS-1){1'b0}},
                                                    {(FRAC_BITS+1){1'b1}}};

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [WIN_W-1:0]  win_ff [MEDIAN_SAMPLES];
   logic signed [WIN_W-1:0]  win_in;
   logic signed [WIN_W-1:0]  med_ff, max_ff, max_in, min_ff, min_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic        [SUM_W-1:0]  diff_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [smps_pkg::OUT_W-1:0] mean_ff, mean_in;
   logic        [smps_pkg::OUT_W-1:0] range_ff, range_in;

   logic signed [PROD_W-1:0] prod_sh;
   logic signed [WIN_W-1:0]  off_sc;
   logic signed [WIN_W-1:0]  cand;
   logic [CNT_W-1:0]         n_lt, n_le;
   logic signed [SUM_W-1:0]  bsum, mean_sh;
   logic        [SUM_W-1:0]  rng_sh;

   // scaling
   assign prod_in = PROD_W'($signed(req_tdata)) * PROD_W'($signed({1'b0, gauge_recip}));
   assign prod_sh = prod_ff >>> SHIFT;
   assign off_sc  = WIN_W'(zero_offset) <<< FRAC_BITS;
   assign win_in  = WIN_W'(prod_sh) - off_sc;

   // median test: candidate is the median when at most MID values lie below it
   // and more than MID lie at or below it
   assign cand = win_ff[idx];
   always_comb begin
      n_lt = '0;
      n_le = '0;
      for (int j = 0; j < MEDIAN_SAMPLES; j++) begin
         if (win_ff[j] < cand)  n_lt = n_lt + CNT_W'(1);
         if (win_ff[j] <= cand) n_le = n_le + CNT_W'(1);
      end
   end
   assign stat.med_found = (n_lt <= CNT_W'(MID)) && (n_le > CNT_W'(MID));

   always_comb begin
      max_in = max_ff;
      min_in = min_ff;
      if (cmd.clear) begin
         max_in = RUN_MIN;
         min_in = RUN_MAX;
      end else if (cmd.upd) begin
         if (med_ff > max_ff) max_in = med_ff;
         if (med_ff < min_ff) min_in = med_ff;
      end
   end

   // truncate toward zero: bias negative sums before the arithmetic shift
   assign bsum    = sum_ff[SUM_W-1] ? sum_ff + MEAN_BIAS : sum_ff;
   assign mean_sh = bsum >>> (FRAC_BITS + 1);
   assign rng_sh  = diff_ff >> FRAC_BITS;

   always_comb begin
      if (mean_sh > SUM_W'(smps_pkg::MEAN_HI))
         mean_in = smps_pkg::MEAN_HI;
      else if (mean_sh < SUM_W'(smps_pkg::MEAN_LO))
         mean_in = smps_pkg::MEAN_LO;
      else
         mean_in = mean_sh[smps_pkg::OUT_W-1:0];
      if (rng_sh > SUM_W'(smps_pkg::RANGE_HI))
         range_in = smps_pkg::RANGE_HI;
      else
         range_in = rng_sh[smps_pkg::OUT_W-1:0];
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);
   assign stat.out_free = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.mul_load)  prod_ff     <= prod_in;
      if (cmd.win_write) win_ff[idx] <= win_in;
      if (cmd.med_test && stat.med_found) med_ff <= cand;
      if (cmd.fin_sum) begin
         sum_ff  <= SUM_W'(max_ff) + SUM_W'(min_ff);
         diff_ff <= SUM_W'(max_ff) - SUM_W'(min_ff);
      end
      if (cmd.out_load) begin
         mean_ff  <= mean_in;
         range_ff <= range_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= RUN_MIN;
         min_ff       <= RUN_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_ff       <= max_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, range_ff, mean_ff};

endmodule

>>> hw/rtl/smps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_ctrl
// Controller: sample and group counters, median candidate sweep, sequencing.
// ----------------------------------------------------------------------------
`include "strain_median_peak_stats_top_macros.svh"

module smps_ctrl #(
   parameter int MEDIAN_SAMPLES = smps_pkg::MEDIAN_SAMPLES_DEF,
   parameter int REPEATS        = smps_pkg::REPEATS_DEF,
   parameter int IDX_W          = (MEDIAN_SAMPLES > 1) ? $clog2(MEDIAN_SAMPLES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output smps_pkg::dp_cmd_type   cmd,
   output logic [IDX_W-1:0]       idx,
   input  smps_pkg::dp_stat_type  stat
);

   localparam int GRP_W = (REPEATS > 1) ? $clog2(REPEATS) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCALE = 3'd1;
   localparam logic [2:0] S_MED   = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_FIN1  = 3'd4;
   localparam logic [2:0] S_FIN2  = 3'd5;

   localparam logic [IDX_W-1:0] SMP_LAST = IDX_W'(MEDIAN_SAMPLES - 1);
   localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(REPEATS - 1);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] smp_ff, smp_in;
   logic [IDX_W-1:0] cand_ff, cand_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic             req_fire;

   // no transaction is taken while reset is held
   assign req_tready = (state_ff == S_IDLE) & ~reset;
   assign req_fire   = req_tvalid & req_tready;
   assign idx        = (state_ff == S_MED) ? cand_ff : smp_ff;

   always_comb begin
      state_in = state_ff;
      smp_in   = smp_ff;
      cand_in  = cand_ff;
      grp_in   = grp_ff;
      cmd      = '0;
      cmd.mul_load = req_fire;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.win_write = 1'b1;
            if (smp_ff == SMP_LAST) begin
               smp_in   = '0;
               cand_in  = '0;
               state_in = S_MED;
            end else begin
               smp_in   = smp_ff + IDX_W'(1);
               state_in = S_IDLE;
            end
         end
         S_MED: begin
            cmd.med_test = 1'b1;
            if (stat.med_found) state_in = S_UPD;
            else                cand_in  = cand_ff + IDX_W'(1);
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (grp_ff == GRP_LAST) begin
               grp_in   = '0;
               state_in = S_FIN1;
            end else begin
               grp_in   = grp_ff + GRP_W'(1);
               state_in = S_IDLE;
            end
         end
         S_FIN1: begin
            cmd.fin_sum = 1'b1;
            state_in    = S_FIN2;
         end
         S_FIN2: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         smp_ff   <= '0;
         cand_ff  <= '0;
         grp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         smp_ff   <= smp_in;
         cand_ff  <= cand_in;
         grp_ff   <= grp_in;
      end
   end

   `SMPS_ASSERT_NXT(a_fire_to_scale, clock, reset, req_fire, state_ff == S_SCALE, "accepted sample not scaled next")
   `SMPS_ASSERT_IMP(a_med_found, clock, reset, (state_ff == S_MED) && (cand_ff == SMP_LAST), stat.med_found, "median sweep found no median")
   `SMPS_ASSERT_IMP(a_med_cnt_clr, clock, reset, state_ff == S_MED, smp_ff == '0, "sample counter not cleared during median")

endmodule

>>> tb/strain_median_peak_stats_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strain_median_peak_stats_top_tb
// Streams raw bridge samples into the strain statistics block under a series
// of gauge/offset register settings. A scoreboard class scales each sample,
// takes group medians and peaks, and checks every midpoint/range result.
// ----------------------------------------------------------------------------
module strain_median_peak_stats_top_tb;

   localparam int     SAMPLE_W     = smps_pkg::SAMPLE_W;
   localparam int     OUT_W        = smps_pkg::OUT_W;
   localparam int     RSP_DATA_W   = smps_pkg::RSP_DATA_W;
   localparam int     CSR_ADDR_W   = smps_pkg::CSR_ADDR_W;
   localparam int     CSR_DATA_W   = smps_pkg::CSR_DATA_W;
   localparam int     FRAC         = smps_pkg::FRAC_BITS_DEF;
   localparam int     GROUP        = smps_pkg::MEDIAN_SAMPLES_DEF;
   localparam int     RUNLEN       = smps_pkg::MEDIAN_SAMPLES_DEF * smps_pkg::REPEATS_DEF;
   localparam longint PEAK_FLOOR   = -(longint'(1) <<< 33);
   localparam longint PEAK_CEIL    = (longint'(1) <<< 33) - 1;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     HOLD_CYCLES  = 600;
   localparam int     LIMIT        = 200000;
   localparam int     PHASES       = 6;
   localparam int     RUNS_PER_PH  = 4;

   typedef enum int {MIX_WIDE, MIX_NARROW, MIX_TIES, MIX_RAILS} sample_mix_type;

   typedef struct packed {
      logic        [OUT_W-1:0] span;
      logic signed [OUT_W-1:0] mean;
   } strain_stats_type;

   class strain_scoreboard;
      logic [SAMPLE_W-1:0] recip;
      logic [SAMPLE_W-1:0] offset;
      longint              window [GROUP];
      int unsigned         fill;
      int unsigned         groups;
      longint              peak_hi;
      longint              peak_lo;
      strain_stats_type    pending [$];
      int                  errors;
      int                  results_seen;

      function new();
         recip        = smps_pkg::GAUGE_RECIP_RST;
         offset       = '0;
         errors       = 0;
         results_seen = 0;
         clear_channel();
      endfunction

      function void clear_channel();
         fill    = 0;
         groups  = 0;
         peak_hi = PEAK_FLOOR;
         peak_lo = PEAK_CEIL;
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      // scale, store, on a full group fold the median into the peaks, and queue a run's result
      function void note_sample(logic [SAMPLE_W-1:0] s);
         longint           raw;
         longint           gain;
         longint           zero;
         longint           med;
         longint           tmp;
         longint           mean;
         longint           span;
         longint           t [GROUP];
         int               i;
         int               j;
         strain_stats_type want;
         raw  = longint'($signed(s));
         gain = longint'(recip);
         zero = longint'($signed(offset));
         window[fill] = ((raw * gain) >>> (SAMPLE_W - FRAC)) - zero * (longint'(1) <<< FRAC);
         fill++;
         if (fill < GROUP) return;
         fill = 0;
         t = window;
         for (i = 1; i < GROUP; i++) begin
            tmp = t[i];
            j = i - 1;
            while (j >= 0 && t[j] > tmp) begin
               t[j + 1] = t[j];
               j--;
            end
            t[j + 1] = tmp;
         end
         med = t[GROUP / 2];
         if (med > peak_hi) peak_hi = med;
         if (med < peak_lo) peak_lo = med;
         groups++;
         if (groups < smps_pkg::REPEATS_DEF) return;
         // longint division truncates toward zero
         mean = (peak_hi + peak_lo) / (longint'(2) <<< FRAC);
         span = (peak_hi - peak_lo) / (longint'(1) <<< FRAC);
         if (mean > longint'(smps_pkg::MEAN_HI)) mean = longint'(smps_pkg::MEAN_HI);
         if (mean < longint'(smps_pkg::MEAN_LO)) mean = longint'(smps_pkg::MEAN_LO);
         if (span > longint'(smps_pkg::RANGE_HI)) span = longint'(smps_pkg::RANGE_HI);
         if (span < 0) span = 0;
         want.mean = mean[OUT_W-1:0];
         want.span = span[OUT_W-1:0];
         pending.push_back(want);
         clear_channel();
      endfunction

      task check_result(logic [RSP_DATA_W-1:0] d);
         strain_stats_type        want;
         logic signed [OUT_W-1:0] got_mean;
         logic        [OUT_W-1:0] got_span;
         results_seen++;
         got_mean = d[OUT_W-1:0];
         got_span = d[2*OUT_W-1:OUT_W];
         if (pending.size() == 0) begin
            report($sformatf("unexpected rsp transaction, tdata %h", d));
            return;
         end
         want = pending.pop_front();
         if (got_mean !== want.mean)
            report($sformatf("mean_strain got %0d expected %0d", got_mean, want.mean));
         if (got_span !== want.span)
            report($sformatf("range_strain got %0d expected %0d", got_span, want.span));
         if (d[RSP_DATA_W-1:2*OUT_W] !== '0)
            report($sformatf("rsp tdata padding not zero: %h", d[RSP_DATA_W-1:2*OUT_W]));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;   // [23:0] raw_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [24:0] mean_strain, [49:25] range_strain
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   strain_scoreboard sb = new();
   int               sent_cnt = 0;
   int               cycle_cnt = 0;
   bit               pressure_done = 0;

   strain_median_peak_stats_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      while (cycle_cnt < LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      @(negedge clock);
      // no idling while sent_cnt is in the burst window
      while (!(sent_cnt >= 250 && sent_cnt < 400) && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(s);
      sent_cnt++;
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == smps_pkg::CSR_GAUGE_RECIP) sb.recip = val[SAMPLE_W-1:0];
      else sb.offset = val[SAMPLE_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(input logic idx, input logic [SAMPLE_W-1:0] want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[SAMPLE_W-1:0] !== want)
         sb.report($sformatf("csr readback at %0d got %h expected %h",
                             {idx, 2'b00}, csr_prdata[SAMPLE_W-1:0], want));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stalls, one long hold-off to back the block up
   initial begin
      rsp_tready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(negedge clock);
         if (!pressure_done && sb.results_seen == 2) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            pressure_done = 1;
         end
         rsp_tready <= (sb.results_seen >= 12 && sb.results_seen < 18) ||
                       ($urandom_range(0, 99) >= 35);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   initial begin
      logic [SAMPLE_W-1:0] directed [RUNLEN];
      logic [SAMPLE_W-1:0] recip_v;
      logic [SAMPLE_W-1:0] offset_v;
      logic [SAMPLE_W-1:0] center;
      logic [SAMPLE_W-1:0] s;
      sample_mix_type      mix;
      int                  p;
      int                  ch;
      int                  k;

      // rails, ties, all-max group, all-min group, alternating bit patterns
      directed = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFF,
                   24'h000005, 24'h000005, 24'hFFFFFD, 24'h000005, 24'h000009,
                   24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                   24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                   24'h555555, 24'hAAAAAA, 24'h000100, 24'hFFFF00, 24'h000100};

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check(smps_pkg::CSR_GAUGE_RECIP, smps_pkg::GAUGE_RECIP_RST);
      csr_read_check(smps_pkg::CSR_ZERO_OFFSET, '0);

      for (k = 0; k < RUNLEN; k++) send_sample(directed[k]);

      for (p = 0; p < PHASES; p++) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         while (sb.pending.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);

         case (p)
            0: begin
               recip_v  = 24'hFFFFFF;
               offset_v = 24'h7FFFFF;
            end
            1: begin
               recip_v  = 24'hFFFFFF;
               offset_v = 24'h800000;
            end
            2: begin
               // zero reciprocal: output collapses to -zero_offset
               recip_v  = '0;
               offset_v = SAMPLE_W'($urandom);
            end
            3: begin
               recip_v  = 24'd1;
               offset_v = SAMPLE_W'($urandom);
            end
            4: begin
               recip_v  = smps_pkg::GAUGE_RECIP_RST;
               offset_v = '0;
            end
            default: begin
               recip_v  = SAMPLE_W'($urandom);
               offset_v = SAMPLE_W'($urandom);
            end
         endcase
         csr_write(smps_pkg::CSR_GAUGE_RECIP, {8'h00, recip_v});
         csr_write(smps_pkg::CSR_ZERO_OFFSET, {{8{offset_v[SAMPLE_W-1]}}, offset_v});
         csr_read_check(smps_pkg::CSR_GAUGE_RECIP, recip_v);
         csr_read_check(smps_pkg::CSR_ZERO_OFFSET, offset_v);

         for (ch = 0; ch < RUNS_PER_PH; ch++) begin
            mix    = sample_mix_type'($urandom_range(0, 3));
            center = SAMPLE_W'($urandom);
            for (k = 0; k < RUNLEN; k++) begin
               case (mix)
                  MIX_WIDE:   s = SAMPLE_W'($urandom);
                  MIX_NARROW: s = SAMPLE_W'(center + $urandom_range(0, 64) - 32);
                  MIX_TIES:   s = SAMPLE_W'(center + $urandom_range(0, 2) - 1);
                  default: begin
                     case ($urandom_range(0, 3))
                        0:       s = 24'h7FFFFF;
                        1:       s = 24'h800000;
                        2:       s = 24'h000000;
                        default: s = 24'hFFFFFF;
                     endcase
                  end
               endcase
               send_sample(s);
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> strain_median_peak_stats_top.f
+incdir+hw/rtl
hw/rtl/smps_pkg.sv
hw/rtl/smps_csr.sv
hw/rtl/smps_dp.sv
hw/rtl/smps_ctrl.sv
hw/rtl/strain_median_peak_stats_top.sv
tb/strain_median_peak_stats_top_tb.sv
